[rtl/core/bcpq_pkg.sv]
// ----------------------------------------------------------------------------
// bcpq_pkg
// Shared codes and control types for the bidirectional packet queue.
// ----------------------------------------------------------------------------
package bcpq_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_CLOCKED    = 2'd0;
    localparam logic [1:0] REG_SYNC_FIRST = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned MAXLEN_W    = 5;

    // Request modes
    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_FWD    = 2'd0;
    localparam logic [1:0] KIND_QUEUED = 2'd1;
    localparam logic [1:0] KIND_DROP   = 2'd2;
    localparam logic [1:0] KIND_IDLE   = 2'd3;

    // Commands from the sequencer to one direction's queue
    typedef struct packed {
        logic push;       // write payload at tail
        logic pop;        // retire the head entry
        logic rd;         // read the head entry into the RAM output register
        logic take_free;  // clear the free-cycle flag
        logic set_free;   // set the free-cycle flag
    } dir_cmd_t;

    // Status from one direction's queue
    typedef struct packed {
        logic free;      // free-cycle flag
        logic empty;     // no entries
        logic has_room;  // occupancy below the current limit
    } dir_stat_t;

endpackage

[rtl/core/bcpq_ram.sv]
// ----------------------------------------------------------------------------
// bcpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcpq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/bcpq_dir.sv]
// ----------------------------------------------------------------------------
// bcpq_dir
// One direction's bounded FIFO: head/tail pointers, occupancy, free-cycle
// flag and the payload RAM.
// ----------------------------------------------------------------------------
module bcpq_dir
    import bcpq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned CNT_W = $clog2(DEPTH + 1),
    parameter int unsigned LIM_W = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dir_cmd_t          cmd,
    input  logic [LIM_W-1:0]  limit,
    input  logic [WIDTH-1:0]  wr_data,
    output logic [WIDTH-1:0]  rd_data,
    output logic [CNT_W-1:0]  count,
    output dir_stat_t         stat
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             free_reg, free_next;

    // Advance pointers and occupancy
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        free_next  = free_reg;
        if (cmd.push)
        begin
            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.take_free)
        begin
            free_next = 1'b0;
        end
        if (cmd.set_free)
        begin
            free_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            free_reg  <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            free_reg  <= free_next;
        end
    end

    // Payload storage
    bcpq_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign count         = count_reg;
    assign stat.free     = free_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.has_room = (LIM_W'(count_reg) < limit);

endmodule

[rtl/core/bidirectional_clocked_packet_queue_top.sv]
// ----------------------------------------------------------------------------
// bidirectional_clocked_packet_queue_top
// Two packet FIFOs, left-to-right and right-to-left, with cut-through in
// free cycles and release of queue heads on clock ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: a packet arrival
//   (mode, from_right, payload) or a clock tick. Output channel
//   (out_valid/out_ready) carries result items; last marks the final one.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   clocked, sync_first and max_length; it is always ready.
//   An arrival gives one result, registered and shown the cycle after
//   acceptance; arrivals can be taken every cycle while no tick is in
//   progress and the receiver keeps up. A tick reads both queue heads
//   from their RAMs, then puts out the left-to-right result and then the
//   right-to-left result, each waiting while the receiver stalls.
//   At reset both queues are empty, both free-cycle flags are set, the
//   block is clocked with cut-through enabled and the full DEPTH limit.
//   The RAM contents need no clearing. When the receiver stalls, the result
//   waits in the output register and no new request is taken until it
//   leaves; a request is taken in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module bidirectional_clocked_packet_queue_top
    import bcpq_pkg::*;
#(
    parameter int unsigned DEPTH         = 16,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [MAXLEN_W-1:0]            cfg_data,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic                           from_right,
    input  logic [PAYLOAD_WIDTH-1:0]       payload,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     kind,
    output logic                           toward_left,
    output logic [PAYLOAD_WIDTH-1:0]       out_payload,
    output logic [$clog2(DEPTH + 1)-1:0]   length_ltr,
    output logic [$clog2(DEPTH + 1)-1:0]   length_rtl,
    output logic                           last
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned LIM_W = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TICK_L = 2'd1;
    localparam logic [1:0] ST_TICK_R = 2'd2;

    // Configuration registers
    logic                clocked_reg;
    logic                sync_first_reg;
    logic [MAXLEN_W-1:0] max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clocked_reg    <= 1'b1;
            sync_first_reg <= 1'b0;
            max_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLOCKED:    clocked_reg    <= cfg_data[0];
                REG_SYNC_FIRST: sync_first_reg <= cfg_data[0];
                REG_MAX_LENGTH: max_length_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Effective queue limit
    logic [LIM_W-1:0] max_ext;
    logic [LIM_W-1:0] limit;

    assign max_ext = LIM_W'(max_length_reg);
    assign limit   = (max_length_reg == '0 || max_ext > LIM_W'(DEPTH)) ?
                     LIM_W'(DEPTH) : max_ext;

    // Direction queues
    dir_cmd_t               cmd_ltr, cmd_rtl;
    dir_stat_t              stat_ltr, stat_rtl;
    logic [PAYLOAD_WIDTH-1:0] rd_ltr, rd_rtl;
    logic [CNT_W-1:0]       cnt_ltr, cnt_rtl;

    bcpq_dir #(
        .DEPTH (DEPTH),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_ltr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ltr),
        .limit   (limit),
        .wr_data (payload),
        .rd_data (rd_ltr),
        .count   (cnt_ltr),
        .stat    (stat_ltr)
    );

    bcpq_dir #(
        .DEPTH (DEPTH),
        .WIDTH (PAYLOAD_WIDTH)
    ) u_rtl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_rtl),
        .limit   (limit),
        .wr_data (payload),
        .rd_data (rd_rtl),
        .count   (cnt_rtl),
        .stat    (stat_rtl)
    );

    // Sequencer and output register
    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         tick_ltr_reg, tick_rtl_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [1:0]               kind_reg, kind_next;
    logic                     toward_left_reg, toward_left_next;
    logic [PAYLOAD_WIDTH-1:0] out_payload_reg, out_payload_next;
    logic [CNT_W-1:0]         length_ltr_reg, length_ltr_next;
    logic [CNT_W-1:0]         length_rtl_reg, length_rtl_next;
    logic                     last_reg, last_next;
    logic                     out_free;
    logic                     load;
    logic                     accept;
    dir_stat_t                stat_sel;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign stat_sel = from_right ? stat_rtl : stat_ltr;

    always_comb
    begin
        state_next       = state_reg;
        cmd_ltr          = '0;
        cmd_rtl          = '0;
        load             = 1'b0;
        kind_next        = KIND_FWD;
        toward_left_next = 1'b0;
        out_payload_next = payload;
        length_ltr_next  = cnt_ltr;
        length_rtl_next  = cnt_rtl;
        last_next        = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_TICK)
                begin
                    // Fetch both heads; results follow
                    cmd_ltr.rd = 1'b1;
                    cmd_rtl.rd = 1'b1;
                    state_next = ST_TICK_L;
                end
                else if (accept)
                begin
                    load             = 1'b1;
                    toward_left_next = from_right;
                    if (!clocked_reg)
                    begin
                        kind_next = KIND_FWD;
                    end
                    else if (!sync_first_reg && stat_sel.free)
                    begin
                        kind_next = KIND_FWD;
                        cmd_ltr.take_free = !from_right;
                        cmd_rtl.take_free = from_right;
                    end
                    else if (stat_sel.has_room)
                    begin
                        kind_next    = KIND_QUEUED;
                        cmd_ltr.push = !from_right;
                        cmd_rtl.push = from_right;
                        if (from_right)
                        begin
                            length_rtl_next = cnt_rtl + 1'b1;
                        end
                        else
                        begin
                            length_ltr_next = cnt_ltr + 1'b1;
                        end
                    end
                    else
                    begin
                        kind_next = KIND_DROP;
                    end
                end
            end
            ST_TICK_L:
            begin
                length_ltr_next = tick_ltr_reg;
                length_rtl_next = tick_rtl_reg;
                last_next       = 1'b0;
                if (stat_ltr.empty)
                begin
                    kind_next        = KIND_IDLE;
                    out_payload_next = '0;
                end
                else
                begin
                    out_payload_next = rd_ltr;
                end
                if (out_free)
                begin
                    load             = 1'b1;
                    cmd_ltr.set_free = stat_ltr.empty;
                    cmd_ltr.pop      = !stat_ltr.empty;
                    state_next       = ST_TICK_R;
                end
            end
            ST_TICK_R:
            begin
                length_ltr_next  = tick_ltr_reg;
                length_rtl_next  = tick_rtl_reg;
                toward_left_next = 1'b1;
                if (stat_rtl.empty)
                begin
                    kind_next        = KIND_IDLE;
                    out_payload_next = '0;
                end
                else
                begin
                    out_payload_next = rd_rtl;
                end
                if (out_free)
                begin
                    load             = 1'b1;
                    cmd_rtl.set_free = stat_rtl.empty;
                    cmd_rtl.pop      = !stat_rtl.empty;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result fields and tick-time lengths
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg        <= kind_next;
            toward_left_reg <= toward_left_next;
            out_payload_reg <= out_payload_next;
            length_ltr_reg  <= length_ltr_next;
            length_rtl_reg  <= length_rtl_next;
            last_reg        <= last_next;
        end
        if (accept && mode == MODE_TICK)
        begin
            tick_ltr_reg <= cnt_ltr;
            tick_rtl_reg <= cnt_rtl;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign toward_left = toward_left_reg;
    assign out_payload = out_payload_reg;
    assign length_ltr  = length_ltr_reg;
    assign length_rtl  = length_rtl_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_TICK) |=> (state_reg == ST_TICK_L))
        else $error("tick request did not start the head release");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_ltr <= CNT_W'(DEPTH)) && (cnt_rtl <= CNT_W'(DEPTH)))
        else $error("queue occupancy above capacity");

    a_first_of_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |->
        (!toward_left && (kind == KIND_FWD || kind == KIND_IDLE)))
        else $error("non-final result is not a left-to-right tick result");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == KIND_IDLE) |-> (out_payload == '0))
        else $error("idle direction result carries a payload");
`endif

endmodule
